### src/v3au_pkg.sv
// Package for the three-component vector arithmetic unit.
// Holds the action codes, the fixed-point constants and the saturation helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package v3au_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = FRAC_BITS + 1;

  localparam logic [2:0] ACT_ADD       = 3'd0;
  localparam logic [2:0] ACT_SUB       = 3'd1;
  localparam logic [2:0] ACT_SCALE     = 3'd2;
  localparam logic [2:0] ACT_DOT       = 3'd3;
  localparam logic [2:0] ACT_CROSS     = 3'd4;
  localparam logic [2:0] ACT_NORM      = 3'd5;
  localparam logic [2:0] ACT_NORMALIZE = 3'd6;
  localparam logic [2:0] ACT_NORM_EPS  = 3'd7;

  localparam logic [30:0] EPSILON_RESET = 31'd66;

  typedef struct packed {
    logic [2:0]       action;
    logic [2:0][31:0] a;
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic             ovf;
    logic [63:0]      sumsq;
  } fe_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [2:0][31:0] a;
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic             ovf;
    logic [31:0]      norm;
    logic             div_en;
  } dv_t;

  // Returns the overflow flag above the saturated 32-bit value.
  function automatic logic [32:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (x < -66'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, x[31:0]};
  endfunction

endpackage
`default_nettype wire

### src/v3au_front.sv
// Front end: six shared multipliers, then the add, subtract, dot, cross and scale results and the sum of squares.
// Depends on v3au_pkg.
`timescale 1ns / 1ps
`default_nettype none
module v3au_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [2:0]            action,
  input  wire logic [2:0][31:0]      a,
  input  wire logic [2:0][31:0]      b,
  input  wire logic [31:0]           factor,
  output logic                       fe_valid,
  output v3au_pkg::fe_t              fe
);
  import v3au_pkg::*;

  logic [5:0][31:0]        ma;
  logic [5:0][31:0]        mb;
  logic                    va;
  logic [2:0]              act_a;
  logic [2:0][31:0]        a_a;
  logic [2:0][31:0]        b_a;
  logic signed [5:0][63:0] p;
  fe_t                     fe_next;

  always_comb begin
    ma = {a[2], a[1], a[0], a[2], a[1], a[0]};
    mb = {a[2], a[1], a[0], a[2], a[1], a[0]};
    unique case (action)
      ACT_SCALE: begin
        mb = {factor, factor, factor, factor, factor, factor};
      end
      ACT_DOT: begin
        mb = {b[2], b[1], b[0], b[2], b[1], b[0]};
      end
      ACT_CROSS: begin
        ma = {a[1], a[0], a[0], a[2], a[2], a[1]};
        mb = {b[0], b[1], b[2], b[0], b[1], b[2]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      fe_valid <= 1'b0;
    end else if (en) begin
      va       <= in_valid;
      fe_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act_a <= action;
      a_a   <= a;
      b_a   <= b;
      for (int k = 0; k < 6; k++) begin
        p[k] <= $signed(ma[k]) * $signed(mb[k]);
      end
      fe <= fe_next;
    end
  end

  always_comb begin
    logic signed [65:0] x [3];
    logic [32:0]        s [3];
    logic signed [65:0] dsum;
    logic [32:0]        ds;
    for (int i = 0; i < 3; i++) begin
      x[i] = '0;
    end
    dsum = {{2{p[0][63]}}, p[0]} + {{2{p[1][63]}}, p[1]} + {{2{p[2][63]}}, p[2]};
    ds = sat32(dsum >>> FRAC_BITS);
    fe_next.action = act_a;
    fe_next.a      = a_a;
    fe_next.r      = '0;
    fe_next.sc     = '0;
    fe_next.ovf    = 1'b0;
    fe_next.sumsq  = p[0] + p[1] + p[2];
    unique case (act_a)
      ACT_ADD: begin
        for (int i = 0; i < 3; i++) begin
          x[i] = {{34{a_a[i][31]}}, a_a[i]} + {{34{b_a[i][31]}}, b_a[i]};
        end
      end
      ACT_SUB: begin
        for (int i = 0; i < 3; i++) begin
          x[i] = {{34{a_a[i][31]}}, a_a[i]} - {{34{b_a[i][31]}}, b_a[i]};
        end
      end
      ACT_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          x[i] = $signed({{2{p[i][63]}}, p[i]}) >>> FRAC_BITS;
        end
      end
      ACT_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          x[i] = $signed({{2{p[2*i][63]}}, p[2*i]} - {{2{p[2*i+1][63]}}, p[2*i+1]})
                 >>> FRAC_BITS;
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      s[i] = sat32(x[i]);
      fe_next.r[i] = s[i][31:0];
    end
    if (act_a == ACT_ADD || act_a == ACT_SUB || act_a == ACT_SCALE || act_a == ACT_CROSS) begin
      fe_next.ovf = s[0][32] | s[1][32] | s[2][32];
    end
    if (act_a == ACT_DOT) begin
      fe_next.sc  = ds[31:0];
      fe_next.ovf = ds[32];
    end
  end

endmodule
`default_nettype wire

### src/v3au_sqrt_cell.sv
// One step of the digit-by-digit square root: consumes two radicand bits.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module v3au_sqrt_cell (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [34:0] rem_in,
  input  wire logic [31:0] root_in,
  input  wire logic [63:0] s_in,
  output logic      [34:0] rem_out,
  output logic      [31:0] root_out,
  output logic      [63:0] s_out
);

  logic [34:0] r2;
  logic [34:0] trial;
  logic        ge;

  assign r2    = {rem_in[32:0], s_in[63:62]};
  assign trial = {1'b0, root_in, 2'b01};
  assign ge    = r2 >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? r2 - trial : r2;
      root_out <= {root_in[30:0], ge};
      s_out    <= {s_in[61:0], 2'b00};
    end
  end

endmodule
`default_nettype wire

### src/v3au_div_cell.sv
// One step of restoring division: produces one quotient bit.
// Depends on v3au_pkg.
`timescale 1ns / 1ps
`default_nettype none
module v3au_div_cell (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [31:0]                      d,
  input  wire logic [31:0]                      rem_in,
  input  wire logic [v3au_pkg::DIV_STEPS-1:0]   n_in,
  input  wire logic [v3au_pkg::DIV_STEPS-1:0]   q_in,
  output logic      [31:0]                      rem_out,
  output logic      [v3au_pkg::DIV_STEPS-1:0]   n_out,
  output logic      [v3au_pkg::DIV_STEPS-1:0]   q_out
);
  import v3au_pkg::*;

  logic [32:0] r2;
  logic [32:0] diff;
  logic        ge;

  assign r2   = {rem_in, n_in[DIV_STEPS-1]};
  assign ge   = r2 >= {1'b0, d};
  assign diff = r2 - {1'b0, d};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? diff[31:0] : r2[31:0];
      n_out   <= {n_in[DIV_STEPS-2:0], 1'b0};
      q_out   <= {q_in[DIV_STEPS-2:0], ge};
    end
  end

endmodule
`default_nettype wire

### src/vector3_arithmetic_unit.sv
// Channel   | Signals                                  | Direction
// request   | in_valid, in_ready, action, a_*, b_*, factor | in
// result    | out_valid, out_ready, r_*, scalar_result, flags | out
// epsilon   | epsilon_valid, epsilon_ready, epsilon    | in
//
// One request is taken per cycle while in_ready is high; its result passes through
// 2 + 32 + 17 + 1 = 52 register stages: the front end, the 32-cell square-root
// chain, the 17-cell divider chains and the output register.
// Synchronous active-high reset empties the pipeline and sets epsilon to 66.
// When a result waits at the output, the whole pipeline holds and in_ready is low.
// Depends on v3au_pkg, v3au_front, v3au_sqrt_cell and v3au_div_cell.
`timescale 1ns / 1ps
`default_nettype none
module vector3_arithmetic_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  action,
  input  wire logic [31:0] a_x,
  input  wire logic [31:0] a_y,
  input  wire logic [31:0] a_z,
  input  wire logic [31:0] b_x,
  input  wire logic [31:0] b_y,
  input  wire logic [31:0] b_z,
  input  wire logic [31:0] factor,
  input  wire logic        epsilon_valid,
  output logic             epsilon_ready,
  input  wire logic [30:0] epsilon,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      r_x,
  output logic [31:0]      r_y,
  output logic [31:0]      r_z,
  output logic [31:0]      scalar_result,
  output logic             was_normalized,
  output logic             overflow
);
  import v3au_pkg::*;

  logic        adv;
  logic [30:0] eps;
  logic        fe_valid;
  fe_t         fe;

  logic                   sv [SQRT_STEPS+1];
  fe_t                    sp [SQRT_STEPS+1];
  logic [34:0]            srem [SQRT_STEPS+1];
  logic [31:0]            sroot [SQRT_STEPS+1];
  logic [63:0]            ss [SQRT_STEPS+1];

  logic                   dvld [DIV_STEPS+1];
  dv_t                    dp [DIV_STEPS+1];
  logic [2:0][31:0]       drem [DIV_STEPS+1];
  logic [2:0][DIV_STEPS-1:0] dn [DIV_STEPS+1];
  logic [2:0][DIV_STEPS-1:0] dq [DIV_STEPS+1];

  logic [2:0][31:0] mag;

  assign adv           = !out_valid || out_ready;
  assign in_ready      = adv;
  assign epsilon_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPSILON_RESET;
    end else if (epsilon_valid) begin
      eps <= epsilon;
    end
  end

  v3au_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (in_valid),
    .action   (action),
    .a        ({a_z, a_y, a_x}),
    .b        ({b_z, b_y, b_x}),
    .factor   (factor),
    .fe_valid (fe_valid),
    .fe       (fe)
  );

  assign sv[0]    = fe_valid;
  assign sp[0]    = fe;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign ss[0]    = fe.sumsq;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    v3au_sqrt_cell u_cell (
      .clk      (clk),
      .en       (adv),
      .rem_in   (srem[k]),
      .root_in  (sroot[k]),
      .s_in     (ss[k]),
      .rem_out  (srem[k+1]),
      .root_out (sroot[k+1]),
      .s_out    (ss[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sp[k+1] <= sp[k];
      end
    end
  end

  always_comb begin
    fe_t   f;
    logic [31:0] nrm;
    f   = sp[SQRT_STEPS];
    nrm = sroot[SQRT_STEPS];
    dvld[0]      = sv[SQRT_STEPS];
    dp[0].action = f.action;
    dp[0].a      = f.a;
    dp[0].r      = f.r;
    dp[0].sc     = f.sc;
    dp[0].ovf    = f.ovf;
    dp[0].norm   = nrm;
    dp[0].div_en = (f.action == ACT_NORMALIZE && nrm != '0)
                || (f.action == ACT_NORM_EPS && nrm > {1'b0, eps});
    for (int i = 0; i < 3; i++) begin
      mag[i]     = f.a[i][31] ? 32'd0 - f.a[i] : f.a[i];
      drem[0][i] = {1'b0, mag[i][31:1]};
      dn[0][i]   = {mag[i][0], {(DIV_STEPS-1){1'b0}}};
      dq[0][i]   = '0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    for (genvar i = 0; i < 3; i++) begin : g_lane
      v3au_div_cell u_cell (
        .clk     (clk),
        .en      (adv),
        .d       (dp[k].norm),
        .rem_in  (drem[k][i]),
        .n_in    (dn[k][i]),
        .q_in    (dq[k][i]),
        .rem_out (drem[k+1][i]),
        .n_out   (dn[k+1][i]),
        .q_out   (dq[k+1][i])
      );
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[k+1] <= 1'b0;
      end else if (adv) begin
        dvld[k+1] <= dvld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dp[k+1] <= dp[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dvld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    dv_t              g;
    logic [2:0][31:0] rv;
    logic [31:0]      q;
    logic             nt;
    logic             nsat;
    g    = dp[DIV_STEPS];
    nt   = g.action == ACT_NORM || g.action == ACT_NORMALIZE || g.action == ACT_NORM_EPS;
    nsat = g.norm[31];
    rv   = g.r;
    for (int i = 0; i < 3; i++) begin
      q = {{(32-DIV_STEPS){1'b0}}, dq[DIV_STEPS][i]};
      if (g.action == ACT_NORM) begin
        rv[i] = '0;
      end else if (g.div_en) begin
        rv[i] = g.a[i][31] ? 32'd0 - q : q;
      end else begin
        rv[i] = g.a[i];
      end
    end
    if (adv) begin
      r_x            <= nt ? rv[0] : g.r[0];
      r_y            <= nt ? rv[1] : g.r[1];
      r_z            <= nt ? rv[2] : g.r[2];
      scalar_result  <= nt ? (nsat ? 32'h7fff_ffff : g.norm) : g.sc;
      was_normalized <= nt && g.action != ACT_NORM && g.div_en;
      overflow       <= nt ? (nsat || (g.action == ACT_NORMALIZE && !g.div_en)) : g.ovf;
    end
  end

endmodule
`default_nettype wire

### src/v3au_checker.sv
// Port-level checker for the vector arithmetic unit, bound to the top level.
// Depends on vector3_arithmetic_unit.
`timescale 1ns / 1ps
`default_nettype none
module v3au_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] r_x,
  input wire logic [31:0] scalar_result,
  input wire logic        was_normalized
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(r_x) && $stable(scalar_result))
    else $error("stalled result changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  a_norm_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_normalized |-> !scalar_result[31])
    else $error("normalized result with negative norm");

endmodule

bind vector3_arithmetic_unit v3au_checker u_v3au_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .r_x            (r_x),
  .scalar_result  (scalar_result),
  .was_normalized (was_normalized)
);
`default_nettype wire
